/* hw/rtl/hso_pkg.sv */
// Shared types and constants for the heat stencil obstacle cell block.
// No dependencies; every other file of the block imports this package.
package hso_pkg;

    localparam int GRID_MAX   = 256;
    localparam int FRAC_BITS  = 24;

    localparam int POS_W      = 8;
    localparam int T_W        = 25;
    localparam int COORD_W    = 16;
    localparam int COEFF_W    = 24;
    localparam int GRID_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Compare width for grid sizes against the clamp value.
    localparam int GRID_CW = ($clog2(GRID_MAX + 1) > GRID_W) ? $clog2(GRID_MAX + 1) : GRID_W;

    // Disk geometry: positions run from -1 to 2^POS_W, scaled to 1/256 grid units.
    localparam int SCALE_SH = 8;
    localparam int PPOS_W   = POS_W + 2;
    localparam int DIFF_W   = PPOS_W + SCALE_SH;
    localparam int SQ_W     = 2 * DIFF_W - 2;
    localparam int RR_W     = 2 * COORD_W;

    // Stencil arithmetic.
    localparam int D2_W   = T_W + 3;
    localparam int PROD_W = D2_W + COEFF_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHV_W  = SUM_W - FRAC_BITS;

    localparam logic [T_W-1:0] TEMP_TOP =
        (FRAC_BITS >= T_W) ? {T_W{1'b1}} : (T_W'(1) << FRAC_BITS);

    localparam logic [COORD_W-1:0]    RST_DISK_COL  = 16'd16384;
    localparam logic [COORD_W-1:0]    RST_DISK_ROW  = 16'd16384;
    localparam logic [COORD_W-1:0]    RST_DISK_RAD  = 16'd3277;
    localparam logic [COEFF_W-1:0]    RST_COEFF_X   = 24'd4026532;
    localparam logic [COEFF_W-1:0]    RST_COEFF_Y   = 24'd4026532;
    localparam logic [T_W-1:0]        RST_THRESHOLD = 25'd17;
    localparam logic [GRID_W-1:0]     RST_GRID_COLS = 9'd128;
    localparam logic [GRID_W-1:0]     RST_GRID_ROWS = 9'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISK_CENTER_COL,
        REG_DISK_CENTER_ROW,
        REG_DISK_RADIUS,
        REG_COEFF_X,
        REG_COEFF_Y,
        REG_SETTLE_THRESHOLD,
        REG_GRID_COLS,
        REG_GRID_ROWS
    } cfg_reg_e;

    typedef struct packed {
        logic [COORD_W-1:0] disk_center_col;
        logic [COORD_W-1:0] disk_center_row;
        logic [COORD_W-1:0] disk_radius;
        logic [COEFF_W-1:0] coeff_x;
        logic [COEFF_W-1:0] coeff_y;
        logic [T_W-1:0]     settle_threshold;
        logic [GRID_W-1:0]  grid_cols;
        logic [GRID_W-1:0]  grid_rows;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] cell_col;
        logic [POS_W-1:0] cell_row;
        logic [T_W-1:0]   temp_center;
        logic [T_W-1:0]   temp_left;
        logic [T_W-1:0]   temp_right;
        logic [T_W-1:0]   temp_below;
        logic [T_W-1:0]   temp_above;
        logic             sweep_start;
    } cell_t;

    typedef struct packed {
        logic [T_W-1:0] temp_next;
        logic [T_W-1:0] cell_delta;
        logic [T_W-1:0] sweep_max_delta;
        logic           settled;
    } result_t;

    // Temperatures and sweep mark carried alongside the geometry stages.
    typedef struct packed {
        logic [T_W-1:0] center;
        logic [T_W-1:0] left;
        logic [T_W-1:0] right;
        logic [T_W-1:0] below;
        logic [T_W-1:0] above;
        logic           start;
    } temps_t;

    // Geometry verdict for one cell.
    typedef struct packed {
        logic frame;
        logic in_center;
        logic in_left;
        logic in_right;
        logic in_below;
        logic in_above;
    } geo_t;

    // Per-stage load enables from the pipeline control.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } adv_t;

    // Cell result ahead of the running maximum.
    typedef struct packed {
        logic [T_W-1:0] temp_next;
        logic [T_W-1:0] cell_delta;
        logic           sweep_start;
    } upd_t;

endpackage

/* hw/rtl/hso_if.sv */
// Valid/ready channel interfaces for cell items and result items.
// Depends on hso_pkg for the payload structs.
interface hso_cell_if;
    import hso_pkg::*;

    logic  valid;
    logic  ready;
    cell_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hso_result_if;
    import hso_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/hso_cfg.sv */
// Configuration register file with a plain write port, no read-back.
// Depends on hso_pkg for the register layout and reset values.
module hso_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hso_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hso_pkg::CFG_DATA_W-1:0] cfg_data,
    output hso_pkg::cfg_t                  cfg
);
    import hso_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_DISK_CENTER_COL:  cfg_next.disk_center_col  = cfg_data[COORD_W-1:0];
                REG_DISK_CENTER_ROW:  cfg_next.disk_center_row  = cfg_data[COORD_W-1:0];
                REG_DISK_RADIUS:      cfg_next.disk_radius      = cfg_data[COORD_W-1:0];
                REG_COEFF_X:          cfg_next.coeff_x          = cfg_data[COEFF_W-1:0];
                REG_COEFF_Y:          cfg_next.coeff_y          = cfg_data[COEFF_W-1:0];
                REG_SETTLE_THRESHOLD: cfg_next.settle_threshold = cfg_data[T_W-1:0];
                REG_GRID_COLS:        cfg_next.grid_cols        = cfg_data[GRID_W-1:0];
                REG_GRID_ROWS:        cfg_next.grid_rows        = cfg_data[GRID_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disk_center_col  <= RST_DISK_COL;
            cfg_reg.disk_center_row  <= RST_DISK_ROW;
            cfg_reg.disk_radius      <= RST_DISK_RAD;
            cfg_reg.coeff_x          <= RST_COEFF_X;
            cfg_reg.coeff_y          <= RST_COEFF_Y;
            cfg_reg.settle_threshold <= RST_THRESHOLD;
            cfg_reg.grid_cols        <= RST_GRID_COLS;
            cfg_reg.grid_rows        <= RST_GRID_ROWS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/hso_geom.sv */
// Geometry stages: frame test and disk membership of a cell and its four neighbors.
// Stage one squares the offsets, stage two sums and compares. Depends on hso_pkg.
module hso_geom (
    input  logic                      clk,
    input  hso_pkg::cfg_t             cfg,
    input  hso_pkg::adv_t             adv,
    input  logic [hso_pkg::POS_W-1:0] col,
    input  logic [hso_pkg::POS_W-1:0] row,
    output hso_pkg::geo_t             geo
);
    import hso_pkg::*;

    // Index 0 is position minus one, 1 the cell itself, 2 position plus one.
    logic [PPOS_W-1:0]          pc      [3];
    logic [PPOS_W-1:0]          pr      [3];
    logic signed [DIFF_W-1:0]   dx      [3];
    logic signed [DIFF_W-1:0]   dy      [3];
    logic signed [2*DIFF_W-1:0] sqfx    [3];
    logic signed [2*DIFF_W-1:0] sqfy    [3];
    logic [SQ_W-1:0]            sqx_next[3];
    logic [SQ_W-1:0]            sqy_next[3];
    logic [SQ_W-1:0]            sqx_reg [3];
    logic [SQ_W-1:0]            sqy_reg [3];
    logic [RR_W-1:0]            rr_next;
    logic [RR_W-1:0]            rr_reg;

    logic [GRID_CW-1:0] cols_ext;
    logic [GRID_CW-1:0] rows_ext;
    logic [GRID_CW-1:0] cols_eff;
    logic [GRID_CW-1:0] rows_eff;
    logic               frame_next;
    logic               frame_reg;

    geo_t geo_next;
    geo_t geo_reg;

    function automatic logic in_disk(input logic [SQ_W-1:0] a,
                                     input logic [SQ_W-1:0] b,
                                     input logic [RR_W-1:0] rr);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s <= (SQ_W + 1)'(rr);
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pc[k] = {2'b00, col} + PPOS_W'(k) - PPOS_W'(1);
            pr[k] = {2'b00, row} + PPOS_W'(k) - PPOS_W'(1);
            dx[k] = $signed({pc[k], {SCALE_SH{1'b0}}})
                  - $signed(DIFF_W'(cfg.disk_center_col));
            dy[k] = $signed({pr[k], {SCALE_SH{1'b0}}})
                  - $signed(DIFF_W'(cfg.disk_center_row));
            sqfx[k] = (2*DIFF_W)'(dx[k]) * (2*DIFF_W)'(dx[k]);
            sqfy[k] = (2*DIFF_W)'(dy[k]) * (2*DIFF_W)'(dy[k]);
            sqx_next[k] = sqfx[k][SQ_W-1:0];
            sqy_next[k] = sqfy[k][SQ_W-1:0];
        end
        rr_next = RR_W'(cfg.disk_radius) * RR_W'(cfg.disk_radius);
    end

    // Clamp the grid sizes, then mark the outer frame and everything past it.
    always_comb
    begin
        cols_ext = GRID_CW'(cfg.grid_cols);
        rows_ext = GRID_CW'(cfg.grid_rows);
        cols_eff = (cols_ext > GRID_CW'(GRID_MAX)) ? GRID_CW'(GRID_MAX) : cols_ext;
        rows_eff = (rows_ext > GRID_CW'(GRID_MAX)) ? GRID_CW'(GRID_MAX) : rows_ext;
        frame_next = (col == '0) || (row == '0)
                  || (GRID_CW'(col) + GRID_CW'(1) >= cols_eff)
                  || (GRID_CW'(row) + GRID_CW'(1) >= rows_eff);
    end

    always_comb
    begin
        geo_next.frame     = frame_reg;
        geo_next.in_center = in_disk(sqx_reg[1], sqy_reg[1], rr_reg);
        geo_next.in_left   = in_disk(sqx_reg[0], sqy_reg[1], rr_reg);
        geo_next.in_right  = in_disk(sqx_reg[2], sqy_reg[1], rr_reg);
        geo_next.in_below  = in_disk(sqx_reg[1], sqy_reg[0], rr_reg);
        geo_next.in_above  = in_disk(sqx_reg[1], sqy_reg[2], rr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            rr_reg    <= rr_next;
            frame_reg <= frame_next;
        end
        if (adv.s2)
        begin
            geo_reg <= geo_next;
        end
    end

    assign geo = geo_reg;

endmodule

/* hw/rtl/hso_update.sv */
// Stencil update stages: ghost substitution and second differences, coefficient
// products, rounding with saturation, and the absolute change. Depends on hso_pkg.
module hso_update (
    input  logic           clk,
    input  hso_pkg::cfg_t  cfg,
    input  hso_pkg::adv_t  adv,
    input  hso_pkg::geo_t  geo,
    input  hso_pkg::temps_t tmp,
    output hso_pkg::upd_t  upd
);
    import hso_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    // Stage three: ghost cells and second differences.
    logic [T_W-1:0]         tl, tr, tb, ta;
    logic signed [D2_W-1:0] d2x_next, d2y_next;
    logic signed [D2_W-1:0] d2x_reg, d2y_reg;
    logic [T_W-1:0]         t3_reg;
    logic                   pass3_reg;
    logic                   start3_reg;

    // Stage four: coefficient products.
    logic signed [PROD_W-1:0] px_next, py_next;
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic [T_W-1:0]           t4_reg;
    logic                     pass4_reg;
    logic                     start4_reg;

    // Stage five: sum, round, saturate.
    logic signed [SUM_W-1:0] t_sh;
    logic signed [SUM_W-1:0] total;
    logic [SHV_W-1:0]        v;
    logic [T_W-1:0]          sat;
    logic [T_W-1:0]          temp5_next;
    logic [T_W-1:0]          temp5_reg;
    logic [T_W-1:0]          t5_reg;
    logic                    start5_reg;

    // Stage six: absolute change.
    logic [T_W-1:0] delta_next;
    upd_t           upd_reg;

    always_comb
    begin
        tl = geo.in_left  ? tmp.center : tmp.left;
        tr = geo.in_right ? tmp.center : tmp.right;
        tb = geo.in_below ? tmp.center : tmp.below;
        ta = geo.in_above ? tmp.center : tmp.above;
        d2x_next = $signed(D2_W'(tl) + D2_W'(tr) - (D2_W'(tmp.center) << 1));
        d2y_next = $signed(D2_W'(tb) + D2_W'(ta) - (D2_W'(tmp.center) << 1));
    end

    always_comb
    begin
        px_next = PROD_W'(d2x_reg) * PROD_W'($signed({1'b0, cfg.coeff_x}));
        py_next = PROD_W'(d2y_reg) * PROD_W'($signed({1'b0, cfg.coeff_y}));
    end

    always_comb
    begin
        t_sh  = $signed(SUM_W'(t4_reg) << FRAC_BITS);
        total = t_sh + SUM_W'(px_reg) + SUM_W'(py_reg) + ROUND_HALF;
        v     = SHV_W'(total >>> FRAC_BITS);
        if (total[SUM_W-1])
        begin
            sat = '0;
        end
        else if (v > SHV_W'(TEMP_TOP))
        begin
            sat = TEMP_TOP;
        end
        else
        begin
            sat = v[T_W-1:0];
        end
        // Frame and obstacle cells keep their old value.
        temp5_next = pass4_reg ? t4_reg : sat;
    end

    always_comb
    begin
        delta_next = (temp5_reg >= t5_reg) ? (temp5_reg - t5_reg) : (t5_reg - temp5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            d2x_reg    <= d2x_next;
            d2y_reg    <= d2y_next;
            t3_reg     <= tmp.center;
            pass3_reg  <= geo.frame || geo.in_center;
            start3_reg <= tmp.start;
        end
        if (adv.s4)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            t4_reg     <= t3_reg;
            pass4_reg  <= pass3_reg;
            start4_reg <= start3_reg;
        end
        if (adv.s5)
        begin
            temp5_reg  <= temp5_next;
            t5_reg     <= t4_reg;
            start5_reg <= start4_reg;
        end
        if (adv.s6)
        begin
            upd_reg.temp_next   <= temp5_reg;
            upd_reg.cell_delta  <= delta_next;
            upd_reg.sweep_start <= start5_reg;
        end
    end

    assign upd = upd_reg;

endmodule

/* hw/rtl/heat_stencil_obstacle_cell_top.sv */
// One explicit heat-diffusion step per grid cell, with a circular insulated
// obstacle, saturation to 0..1.0 and a running per-sweep maximum of the change.
// Depends on hso_pkg, hso_if, hso_cfg, hso_geom and hso_update.
//
// The block takes one cell per clock and offers its result after these stages:
// in order, an input register, two geometry stages (offset squares,
// then disk compares), four update stages (ghost cells and second differences,
// coefficient multiplies, rounding and saturation, absolute change) and the
// output register, where the sweep maximum and the settled flag are formed.
// Every stage has its own valid bit, so a stalled result only holds the stages
// behind it that are full; with the result side ready the rate is one cell per
// cycle. Write configuration only while no cell is in flight.
module heat_stencil_obstacle_cell_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hso_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hso_pkg::CFG_DATA_W-1:0] cfg_data,
    hso_cell_if.sink                       cell_in,
    hso_result_if.source                   result
);
    import hso_pkg::*;

    localparam int NSTG = 8;

    cfg_t   cfg;
    adv_t   adv;
    geo_t   geo;
    upd_t   upd;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG:0]   rdy;

    cell_t   in_reg;
    temps_t  tmp1_reg;
    temps_t  tmp2_reg;
    temps_t  tmp0;

    logic [T_W-1:0] max_reg;
    logic [T_W-1:0] max_base;
    logic [T_W-1:0] max_next;
    result_t        out_reg;
    result_t        out_next;

    hso_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        rdy[NSTG] = result.ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? cell_in.valid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_comb
    begin
        adv.s1 = rdy[1];
        adv.s2 = rdy[2];
        adv.s3 = rdy[3];
        adv.s4 = rdy[4];
        adv.s5 = rdy[5];
        adv.s6 = rdy[6];
    end

    always_comb
    begin
        tmp0.center = in_reg.temp_center;
        tmp0.left   = in_reg.temp_left;
        tmp0.right  = in_reg.temp_right;
        tmp0.below  = in_reg.temp_below;
        tmp0.above  = in_reg.temp_above;
        tmp0.start  = in_reg.sweep_start;
    end

    hso_geom u_geom (
        .clk (clk),
        .cfg (cfg),
        .adv (adv),
        .col (in_reg.cell_col),
        .row (in_reg.cell_row),
        .geo (geo)
    );

    hso_update u_update (
        .clk (clk),
        .cfg (cfg),
        .adv (adv),
        .geo (geo),
        .tmp (tmp2_reg),
        .upd (upd)
    );

    // Restart the maximum on the first cell of a sweep, then fold in this cell.
    always_comb
    begin
        max_base = upd.sweep_start ? '0 : max_reg;
        max_next = (upd.cell_delta > max_base) ? upd.cell_delta : max_base;
        out_next.temp_next       = upd.temp_next;
        out_next.cell_delta      = upd.cell_delta;
        out_next.sweep_max_delta = max_next;
        out_next.settled         = max_next < cfg.settle_threshold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            max_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
            if (rdy[NSTG-1] && v_reg[NSTG-2])
            begin
                max_reg <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            in_reg <= cell_in.data;
        end
        if (rdy[1])
        begin
            tmp1_reg <= tmp0;
        end
        if (rdy[2])
        begin
            tmp2_reg <= tmp1_reg;
        end
        if (rdy[NSTG-1])
        begin
            out_reg <= out_next;
        end
    end

    assign cell_in.ready = rdy[0];
    assign result.valid  = v_reg[NSTG-1];
    assign result.data   = out_reg;

    a_max_covers_cell: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.data.sweep_max_delta >= result.data.cell_delta)
        else $error("sweep maximum below cell change");

    a_changed_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.cell_delta != '0) |-> result.data.temp_next <= TEMP_TOP)
        else $error("updated temperature above 1.0");

    a_max_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy[NSTG-1] && v_reg[NSTG-2]) |=> max_reg == result.data.sweep_max_delta)
        else $error("running maximum and result disagree");

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> cell_in.ready)
        else $error("empty input stage refuses a transfer");

endmodule
